[design/cgfd_pkg.sv]
// ----------------------------------------------------------------------------
// cgfd_pkg
// Shared constants, types and functions of the cell group frame decoder.
// ----------------------------------------------------------------------------
package cgfd_pkg;

    // Frame layout
    localparam int STACK_DEVICES = 16;
    localparam int DATA_BYTES    = 6;
    localparam int HEADER_LEN    = 4;
    localparam int SLOT_LEN      = DATA_BYTES + 2;
    localparam int FRAME_LEN     = HEADER_LEN + SLOT_LEN * STACK_DEVICES;
    localparam int READINGS      = DATA_BYTES / 2;

    // Widths
    localparam int POS_W  = 8;
    localparam int SLOT_W = $clog2(SLOT_LEN);
    localparam int DEV_W  = 4;
    localparam int LANE_W = 2;
    localparam int VOLT_W = 13;
    localparam int CRC_W  = 16;

    // Byte offsets inside one device slot
    localparam logic [SLOT_W-1:0] SLOT_FIRST_DATA = SLOT_W'(0);
    localparam logic [SLOT_W-1:0] SLOT_CHECK_HI   = SLOT_W'(DATA_BYTES);
    localparam logic [SLOT_W-1:0] SLOT_CHECK_LO   = SLOT_W'(DATA_BYTES + 1);

    localparam logic [POS_W-1:0] POS_HEADER_END = POS_W'(HEADER_LEN);
    localparam logic [POS_W-1:0] POS_FRAME_END  = POS_W'(FRAME_LEN);
    localparam logic [DEV_W-1:0] DEV_LAST       = DEV_W'(STACK_DEVICES - 1);

    // CRC-15 parameters
    localparam logic [CRC_W-1:0] CRC_POLY = 16'h4599;
    localparam logic [CRC_W-1:0] CRC_SEED = 16'd16;
    localparam logic [CRC_W-1:0] CRC_TOP  = 16'h4000;

    // Divide by 10: (x * 0xCCCD) >> 19 is exact for any 16-bit x
    localparam logic [15:0] DIV10_MUL   = 16'hCCCD;
    localparam int          DIV10_SHIFT = 19;

    // Controls from the slot sequencer to the check unit
    typedef struct packed {
        logic load_seed;   // start from the seed
        logic update;      // fold the byte into the remainder
        logic capture_hi;  // keep the high byte of the check word
    } pec_ctrl_t;

    // One entry of the byte-wise CRC-15 table
    function automatic logic [CRC_W-1:0] crc_table_entry(input logic [7:0] idx);
        logic [CRC_W-1:0] r;
        logic             top;
        r = {1'b0, idx, 7'b0000000};
        for (int b = 0; b < 8; b++)
        begin
            top = (r & CRC_TOP) != '0;
            r   = {r[CRC_W-2:0], 1'b0};
            if (top)
            begin
                r = r ^ CRC_POLY;
            end
        end
        return r;
    endfunction

    // Fold one byte into the remainder
    function automatic logic [CRC_W-1:0] crc_update(input logic [CRC_W-1:0] rem,
                                                    input logic [7:0] data);
        logic [7:0] addr;
        addr = rem[14:7] ^ data;
        return {rem[7:0], 8'h00} ^ crc_table_entry(addr);
    endfunction

    // Cell slot offset of a register group
    function automatic logic [7:0] group_offset(input logic [1:0] grp);
        logic [7:0] off;
        unique case (grp)
            2'd0: off = 8'd0;
            2'd1: off = 8'd3;
            2'd2: off = 8'd5;
            default: off = 8'd8;
        endcase
        return off;
    endfunction

    // Number of readings used by a register group
    function automatic logic [1:0] group_count(input logic [1:0] grp);
        logic [1:0] cnt;
        unique case (grp)
            2'd0: cnt = 2'd3;
            2'd1: cnt = 2'd2;
            2'd2: cnt = 2'd3;
            default: cnt = 2'd1;
        endcase
        return cnt;
    endfunction

endpackage

[design/cell_group_frame_decoder.sv]
// ----------------------------------------------------------------------------
// cell_group_frame_decoder
// Splits a daisy-chain cell register read into device slots, checks each
// slot's CRC-15 and emits three scaled readings per device.
// ----------------------------------------------------------------------------
//
//  channel   | dir | tdata                         | tuser                   | tlast
//  ----------+-----+-------------------------------+-------------------------+------------
//  s_axis_*  | in  | rx_byte                       | frame_start, group      | -
//  m_axis_*  | out | device, first_cell, cells_... | pec_ok                  | last_device
//
//  One byte is taken per cycle while not stalled and updates the slot state as it is
//  taken; the low check byte of a slot loads the result register, so a result appears
//  in the following cycle. The divide by 10 (one 16x16 multiply) and the CRC table
//  lookup both run on the byte being taken. Reset clears the byte position and the
//  result valid and loads the seed into the remainder. A waiting result stalls only
//  a byte offered at the low check byte position; all other bytes keep flowing.
//
module cell_group_frame_decoder
    import cgfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic [2:0]  s_axis_tuser,   // [0] frame_start, [2:1] group

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [3:0] device, [11:4] first_cell, [13:12] cells_written,
    // [26:14] voltage_a, [39:27] voltage_b, [52:40] voltage_c, [55:53] zero
    output logic [55:0] m_axis_tdata,
    output logic [0:0]  m_axis_tuser,   // [0] pec_ok
    output logic        m_axis_tlast    // last_device
);

    logic              s_fire;
    logic [7:0]        rx_byte;
    logic              frame_start;
    logic [1:0]        grp;

    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  pos_next;
    logic [POS_W-1:0]  pos_eff;
    logic [POS_W-1:0]  rel;
    logic [SLOT_W-1:0] slot_k;
    logic [DEV_W-1:0]  dev;
    logic [LANE_W-1:0] lane;
    logic              in_frame;
    logic              in_data;
    logic              is_data;
    logic              is_check_lo;
    logic              check_lo_state;
    logic              res_gen;

    logic [7:0]        lo_reg [READINGS];
    logic [VOLT_W-1:0] q_reg  [READINGS];
    logic [7:0]        lo_sel;
    logic [31:0]       prod;

    pec_ctrl_t         pec_ctrl;
    logic              pec_ok;

    logic              m_valid_reg;
    logic [DEV_W-1:0]  dev_reg;
    logic [7:0]        first_cell_reg;
    logic [1:0]        cells_reg;
    logic [VOLT_W-1:0] volt_reg [READINGS];
    logic              pec_ok_reg;
    logic              last_reg;
    logic [7:0]        first_cell;

    assign rx_byte     = s_axis_tdata;
    assign frame_start = s_axis_tuser[0];
    assign grp         = s_axis_tuser[2:1];

    // Decode slot offset and device from the current position
    always_comb
    begin
        pos_eff  = frame_start ? '0 : pos_reg;
        in_frame = (pos_eff < POS_FRAME_END);
        in_data  = in_frame && (pos_eff >= POS_HEADER_END);
        rel      = pos_eff - POS_HEADER_END;
        slot_k   = rel[SLOT_W-1:0];
        dev      = rel[SLOT_W +: DEV_W];
        lane     = slot_k[SLOT_W-1:1];
        is_data     = in_data && (slot_k < SLOT_CHECK_HI);
        is_check_lo = in_data && (slot_k == SLOT_CHECK_LO);
        pos_next    = in_frame ? pos_eff + 1'b1 : pos_eff;
    end

    // Stall only a byte offered at the low check byte position while a result waits
    assign check_lo_state = (pos_reg >= POS_HEADER_END) && (pos_reg < POS_FRAME_END)
                            && ((pos_reg - POS_HEADER_END) % SLOT_LEN == SLOT_LEN - 1);
    assign s_axis_tready  = !(check_lo_state && m_valid_reg && !m_axis_tready);
    assign s_fire         = s_axis_tvalid && s_axis_tready;
    assign res_gen        = is_check_lo;

    // Advance the byte position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else if (s_fire)
        begin
            pos_reg <= pos_next;
        end
    end

    // Drive the check unit
    always_comb
    begin
        pec_ctrl.load_seed  = frame_start || (is_data && slot_k == SLOT_FIRST_DATA);
        pec_ctrl.update     = is_data;
        pec_ctrl.capture_hi = in_data && (slot_k == SLOT_CHECK_HI);
    end

    cgfd_pec u_pec (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (s_fire),
        .ctrl    (pec_ctrl),
        .rx_byte (rx_byte),
        .pec_ok  (pec_ok)
    );

    // Select the stored low byte of the current reading
    always_comb
    begin
        lo_sel = '0;
        for (int i = 0; i < READINGS; i++)
        begin
            if (lane == LANE_W'(i))
            begin
                lo_sel = lo_reg[i];
            end
        end
    end

    // Divide the completed reading by 10
    assign prod = {rx_byte, lo_sel} * DIV10_MUL;

    // Store low bytes and quotients per reading
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < READINGS; i++)
        begin
            if (s_fire && is_data && lane == LANE_W'(i))
            begin
                if (!slot_k[0])
                begin
                    lo_reg[i] <= rx_byte;
                end
                else
                begin
                    q_reg[i] <= prod[DIV10_SHIFT +: VOLT_W];
                end
            end
        end
    end

    assign first_cell = {1'b0, dev, 3'b000} + {4'b0000, dev} + group_offset(grp);

    // Load the result register and drop valid once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (s_fire && res_gen)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    // Hold the result payload
    always_ff @(posedge clk)
    begin
        if (s_fire && res_gen)
        begin
            dev_reg        <= dev;
            first_cell_reg <= first_cell;
            cells_reg      <= group_count(grp);
            pec_ok_reg     <= pec_ok;
            last_reg       <= (dev == DEV_LAST);
            for (int i = 0; i < READINGS; i++)
            begin
                volt_reg[i] <= pec_ok ? q_reg[i] : '0;
            end
        end
    end

    assign m_axis_tvalid   = m_valid_reg;
    assign m_axis_tdata    = {3'b000, volt_reg[2], volt_reg[1], volt_reg[0],
                              cells_reg, first_cell_reg, dev_reg};
    assign m_axis_tuser[0] = pec_ok_reg;
    assign m_axis_tlast    = last_reg;

`ifndef SYNTH
    // A new result never lands on one still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_fire && res_gen && m_valid_reg && !m_axis_tready))
        else $error("result register overwritten while stalled");

    // Position never runs past the frame
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_FRAME_END)
        else $error("byte position beyond frame end");

    // A completed slot shows up on the output next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (s_fire && res_gen) |=> m_axis_tvalid)
        else $error("result missing after check byte");

    // Failed check carries zero readings
    a_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |->
        (m_axis_tdata[52:14] == '0))
        else $error("nonzero readings on check failure");
`endif

endmodule

[design/cgfd_pec.sv]
// ----------------------------------------------------------------------------
// cgfd_pec
// CRC-15 remainder over the data bytes of one device and comparison with
// the received big-endian check word.
// ----------------------------------------------------------------------------
module cgfd_pec
    import cgfd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,      // a word is taken this cycle
    input  pec_ctrl_t        ctrl,
    input  logic [7:0]       rx_byte,
    output logic             pec_ok     // valid while the low check byte is present
);

    logic [CRC_W-1:0] crc_reg;
    logic [CRC_W-1:0] crc_next;
    logic [CRC_W-1:0] crc_base;
    logic [7:0]       check_hi_reg;
    logic [CRC_W-1:0] calc;

    // Pick the start value and fold in the data byte
    always_comb
    begin
        crc_base = ctrl.load_seed ? CRC_SEED : crc_reg;
        if (ctrl.update)
        begin
            crc_next = crc_update(crc_base, rx_byte);
        end
        else
        begin
            crc_next = crc_base;
        end
    end

    // Hold the remainder
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg <= CRC_SEED;
        end
        else if (step)
        begin
            crc_reg <= crc_next;
        end
    end

    // Keep the high byte of the check word
    always_ff @(posedge clk)
    begin
        if (step && ctrl.capture_hi)
        begin
            check_hi_reg <= rx_byte;
        end
    end

    // Compare the doubled remainder with the received word
    assign calc   = {crc_reg[CRC_W-2:0], 1'b0};
    assign pec_ok = (calc == {check_hi_reg, rx_byte});

endmodule

[tb/tb_cell_group_frame_decoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cell_group_frame_decoder
// Streams daisy-chain cell read frames into the decoder and checks every
// device readout against a cycle-free model of the slot layout, the CRC-15
// and the divide by ten. Both stream sides idle in random bursts, and the
// output side holds off once for a long stretch to back up the input.
// ----------------------------------------------------------------------------
module tb_cell_group_frame_decoder;
    import cgfd_pkg::*;

    // Worst case is about 1400 words, each with the longest sender gap and output stall,
    // plus the long hold-off; allow several times that.
    localparam int CYCLE_LIMIT = 200000;
    localparam int WORD_TARGET = 1400;
    localparam int HOLD_AFTER  = 300;
    localparam int HOLD_CYCLES = 400;
    localparam int CALM_WORDS  = 200;
    localparam int DRAIN_WAIT  = 20;

    typedef struct packed {
        logic [7:0] rx;
        logic       fs;
        logic [1:0] grp;
    } rx_word_t;

    typedef struct packed {
        logic [3:0]  device;
        logic [7:0]  first_cell;
        logic [1:0]  cells;
        logic [12:0] volt_a;
        logic [12:0] volt_b;
        logic [12:0] volt_c;
        logic        pec_ok;
        logic        last;
    } readout_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;   // [7:0] rx_byte
    logic [2:0]  s_axis_tuser = '0;   // [0] frame_start, [2:1] group
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [3:0] device, [11:4] first_cell, [13:12] cells_written,
    // [26:14] voltage_a, [39:27] voltage_b, [52:40] voltage_c
    logic [55:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;        // [0] pec_ok
    logic        m_axis_tlast;        // last_device

    rx_word_t    rx_words [$];
    readout_t    readout_q [$];
    int          word_count = 0;
    int          bytes_taken = 0;
    int          cycles = 0;
    bit          calm = 1'b0;
    bit          failed = 1'b0;

    // Predictor state
    int          frame_pos = 0;
    logic [15:0] slot_crc = CRC_SEED;
    logic [7:0]  slot_data [6];
    logic [7:0]  check_hi;

    // Driver and receiver locals
    int          gap_left = 0;
    int          stall_left = 0;
    bit          hold_done = 1'b0;
    rx_word_t    nxt;
    readout_t    want;

    cell_group_frame_decoder uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Fold one byte into the CRC-15 remainder, table entry built bit by bit
    function automatic logic [15:0] pec_fold(input logic [15:0] rem, input logic [7:0] b);
        logic [15:0] ent;
        logic        top;
        ent = {1'b0, rem[14:7] ^ b, 7'b0};
        for (int i = 0; i < 8; i++)
        begin
            top = ent[14];
            ent = {ent[14:0], 1'b0};
            if (top)
            begin
                ent = ent ^ CRC_POLY;
            end
        end
        return {rem[7:0], 8'h00} ^ ent;
    endfunction

    // Work out the readout (if any) that one accepted byte causes
    task automatic decode_byte(input logic [7:0] b, input logic fs, input logic [1:0] g);
        int          k;
        int          dev;
        logic [15:0] calc;
        logic [15:0] recv;
        logic [15:0] raw;
        logic [12:0] volts [3];
        readout_t    r;
        if (fs)
        begin
            frame_pos = 0;
            slot_crc  = CRC_SEED;
        end
        if (frame_pos >= FRAME_LEN)
        begin
            return;
        end
        frame_pos = frame_pos + 1;
        if (frame_pos - 1 < HEADER_LEN)
        begin
            return;
        end
        k   = (frame_pos - 1 - HEADER_LEN) % SLOT_LEN;
        dev = (frame_pos - 1 - HEADER_LEN) / SLOT_LEN;
        if (k < DATA_BYTES)
        begin
            if (k == 0)
            begin
                slot_crc = CRC_SEED;
            end
            slot_data[k] = b;
            slot_crc = pec_fold(slot_crc, b);
        end
        else if (k == DATA_BYTES)
        begin
            check_hi = b;
        end
        else
        begin
            calc = {slot_crc[14:0], 1'b0};
            recv = {check_hi, b};
            for (int i = 0; i < 3; i++)
            begin
                raw = {slot_data[2*i+1], slot_data[2*i]};
                volts[i] = (calc == recv) ? 13'(raw / 16'd10) : 13'd0;
            end
            r.device = 4'(dev);
            case (g)
                2'd0:    begin r.first_cell = 8'(dev * 9);     r.cells = 2'd3; end
                2'd1:    begin r.first_cell = 8'(dev * 9 + 3); r.cells = 2'd2; end
                2'd2:    begin r.first_cell = 8'(dev * 9 + 5); r.cells = 2'd3; end
                default: begin r.first_cell = 8'(dev * 9 + 8); r.cells = 2'd1; end
            endcase
            r.volt_a = volts[0];
            r.volt_b = volts[1];
            r.volt_c = volts[2];
            r.pec_ok = (calc == recv);
            r.last   = (dev == STACK_DEVICES - 1);
            readout_q.push_back(r);
        end
    endtask

    task automatic queue_word(input logic [7:0] b, input logic fs, input logic [1:0] g,
                              input bit counted);
        rx_words.push_back('{rx: b, fs: fs, grp: g});
        if (counted)
        begin
            word_count++;
        end
    endtask

    function automatic logic [1:0] any_group();
        return 2'($urandom_range(0, 3));
    endfunction

    // Six data bytes, biased toward the all-zero and all-one extremes
    function automatic logic [47:0] slot_payload();
        logic [47:0] d;
        int          sel;
        for (int i = 0; i < 6; i++)
        begin
            sel = $urandom_range(0, 7);
            d[8*i +: 8] = (sel == 0) ? 8'h00 : (sel == 1) ? 8'hff : 8'($urandom);
        end
        return d;
    endfunction

    // Queue one device slot (or its first keep bytes) with a matching check word, or a corrupted one if bad
    task automatic push_slot(input logic [47:0] d, input bit bad, input logic [1:0] g_end,
                             input int keep);
        logic [15:0] crc;
        logic [15:0] word;
        logic [7:0]  b;
        crc = CRC_SEED;
        for (int i = 0; i < 6; i++)
        begin
            crc = pec_fold(crc, d[8*i +: 8]);
        end
        word = {crc[14:0], 1'b0};
        if (bad)
        begin
            word = word ^ (16'h0001 << $urandom_range(0, 15));
        end
        for (int i = 0; i < keep; i++)
        begin
            b = (i < 6) ? d[8*i +: 8] : (i == 6) ? word[15:8] : word[7:0];
            queue_word(b, 1'b0, (i == 7) ? g_end : any_group(), 1'b1);
        end
    endtask

    // One frame: mostly complete, sometimes cut short, sometimes followed by noise
    task automatic push_frame();
        int n_dev;
        int cut;
        queue_word(8'($urandom), 1'b1, any_group(), 1'b1);
        for (int i = 1; i < HEADER_LEN; i++)
        begin
            queue_word(8'($urandom), 1'b0, any_group(), 1'b1);
        end
        if ($urandom_range(0, 3) == 0)
        begin
            n_dev = $urandom_range(0, STACK_DEVICES - 1);
            cut   = $urandom_range(0, SLOT_LEN - 1);
        end
        else
        begin
            n_dev = STACK_DEVICES;
            cut   = 0;
        end
        for (int i = 0; i < n_dev; i++)
        begin
            push_slot(slot_payload(), $urandom_range(0, 5) == 0, any_group(), SLOT_LEN);
        end
        if (cut > 0)
        begin
            push_slot(slot_payload(), 1'b0, any_group(), cut);
        end
        // trailing bytes past the frame end are dropped by the block
        if (n_dev == STACK_DEVICES)
        begin
            repeat ($urandom_range(0, 6)) queue_word(8'($urandom), 1'b0, any_group(), 1'b0);
        end
        if ($urandom_range(0, 7) == 0)
        begin
            repeat ($urandom_range(5, 30))
                queue_word(8'($urandom), $urandom_range(0, 7) == 0, any_group(), 1'b1);
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] exp_v,
                               input logic [15:0] act_v);
        if (act_v !== exp_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            failed = 1'b1;
        end
    endtask

    // Stimulus, reset and end of run
    initial
    begin
        // first byte after reset carries no frame start and still counts as byte 0
        queue_word(8'ha5, 1'b0, 2'd0, 1'b1);
        queue_word(8'h00, 1'b0, 2'd1, 1'b1);
        queue_word(8'hff, 1'b0, 2'd2, 1'b1);
        queue_word(8'h5a, 1'b0, 2'd3, 1'b1);
        // full-scale readings, zero readings, then a bad check word
        push_slot(48'hffff_ffff_ffff, 1'b0, 2'd3, SLOT_LEN);
        push_slot(48'h0000_0000_0000, 1'b0, 2'd0, SLOT_LEN);
        push_slot(48'h0009_000a_fff6, 1'b1, 2'd1, SLOT_LEN);
        while (word_count < WORD_TARGET)
        begin
            push_frame();
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        @(negedge clk);
        while (rx_words.size() != 0 || s_axis_tvalid || readout_q.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_WAIT) @(posedge clk);
        if (!failed)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Drive bytes; predict on each accepted word
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                decode_byte(s_axis_tdata, s_axis_tuser[0], s_axis_tuser[2:1]);
                bytes_taken <= bytes_taken + 1;
            end
            calm <= (rx_words.size() < CALM_WORDS);
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (gap_left == 0 && !calm && $urandom_range(0, 4) == 0)
                begin
                    gap_left = $urandom_range(1, 8);
                end
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (rx_words.size() > 0)
                begin
                    nxt = rx_words.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= nxt.rx;
                    s_axis_tuser  <= {nxt.grp, nxt.fs};
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Output ready: random stall bursts plus one long hold-off to back up the input
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (!hold_done && bytes_taken >= HOLD_AFTER)
            begin
                hold_done  = 1'b1;
                stall_left = HOLD_CYCLES;
            end
            else if (stall_left == 0 && !calm && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 8);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Compare each readout word with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (readout_q.size() == 0)
            begin
                $error("unexpected readout for device %0d", m_axis_tdata[3:0]);
                failed = 1'b1;
            end
            else
            begin
                want = readout_q.pop_front();
                check_field("device", 16'(want.device), 16'(m_axis_tdata[3:0]));
                check_field("first_cell", 16'(want.first_cell), 16'(m_axis_tdata[11:4]));
                check_field("cells_written", 16'(want.cells), 16'(m_axis_tdata[13:12]));
                check_field("voltage_a", 16'(want.volt_a), 16'(m_axis_tdata[26:14]));
                check_field("voltage_b", 16'(want.volt_b), 16'(m_axis_tdata[39:27]));
                check_field("voltage_c", 16'(want.volt_c), 16'(m_axis_tdata[52:40]));
                check_field("pec_ok", 16'(want.pec_ok), 16'(m_axis_tuser[0]));
                check_field("last_device", 16'(want.last), 16'(m_axis_tlast));
            end
        end
    end

    // Hard stop
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

endmodule

[filelist.f]
design/cgfd_pkg.sv
design/cgfd_pec.sv
design/cell_group_frame_decoder.sv
tb/tb_cell_group_frame_decoder.sv
